/* rtl/i2c_master_register_access_defines.svh */
// assertion macros shared by the i2c register access rtl
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

`ifndef SYNTHESIS

`define I2CM_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("i2cm assertion failed");

`define I2CM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");

`else

`define I2CM_ASSERT(name, clk, rst_n, prop)
`define I2CM_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/i2cm_pkg.sv */
// types and codes for the i2c register access master
package i2cm_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [15:0] byte_count;
        logic [7:0]  write_data;
        logic        sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       data_taken;
        logic       done_res;
        logic       error;
        logic       busy_res;
    } t_out_item;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_START0    = 4'd1;
    localparam logic [3:0] PH_START1    = 4'd2;
    localparam logic [3:0] PH_START2    = 4'd3;
    localparam logic [3:0] PH_TX_LOW    = 4'd4;
    localparam logic [3:0] PH_TX_HIGH   = 4'd5;
    localparam logic [3:0] PH_ACK_LOW   = 4'd6;
    localparam logic [3:0] PH_ACK_HIGH  = 4'd7;
    localparam logic [3:0] PH_RX_LOW    = 4'd8;
    localparam logic [3:0] PH_RX_HIGH   = 4'd9;
    localparam logic [3:0] PH_MACK_LOW  = 4'd10;
    localparam logic [3:0] PH_MACK_HIGH = 4'd11;
    localparam logic [3:0] PH_STOP0     = 4'd12;
    localparam logic [3:0] PH_STOP1     = 4'd13;
    localparam logic [3:0] PH_STOP2     = 4'd14;

    localparam logic [1:0] STG_DEV_W = 2'd0;
    localparam logic [1:0] STG_REG   = 2'd1;
    localparam logic [1:0] STG_DEV_R = 2'd2;
    localparam logic [1:0] STG_DATA  = 2'd3;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

endpackage

/* rtl/i2cm_seq.sv */
// phase sequencer: one half-bit phase per accepted item
`include "i2c_master_register_access_defines.svh"

module i2cm_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  i2cm_pkg::t_in_item i_item,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    output i2cm_pkg::t_out_item o_result
);

    logic [7:0]  r_ack_timeout;
    logic [3:0]  r_phase,     n_phase;
    logic [2:0]  r_bit_idx,   n_bit_idx;
    logic [7:0]  r_shift,     n_shift;
    logic [15:0] r_left,      n_left;
    logic [7:0]  r_ack_cnt,   n_ack_cnt;
    logic [6:0]  r_dev,       n_dev;
    logic [7:0]  r_reg,       n_reg;
    logic        r_read_mode, n_read_mode;
    logic [1:0]  r_stage,     n_stage;
    logic        r_abort,     n_abort;

    logic        bitv;
    logic [2:0]  bit_inc;
    logic [7:0]  rx_shift;
    i2cm_pkg::t_out_item res;

    assign bitv     = r_shift[7];
    assign bit_inc  = r_bit_idx + 3'd1;
    assign rx_shift = {r_shift[6:0], i_item.sda_in};

    always_comb begin
        n_phase     = r_phase;
        n_bit_idx   = r_bit_idx;
        n_shift     = r_shift;
        n_left      = r_left;
        n_ack_cnt   = r_ack_cnt;
        n_dev       = r_dev;
        n_reg       = r_reg;
        n_read_mode = r_read_mode;
        n_stage     = r_stage;
        n_abort     = r_abort;
        res         = '0;
        res.scl_out = 1'b1;
        res.sda_out = 1'b1;

        unique case (r_phase)
            i2cm_pkg::PH_IDLE: begin
                if (i_item.operation == i2cm_pkg::OP_WRITE ||
                    i_item.operation == i2cm_pkg::OP_READ) begin
                    n_dev       = i_item.dev_addr;
                    n_reg       = i_item.reg_addr;
                    n_left      = i_item.byte_count;
                    n_read_mode = (i_item.operation == i2cm_pkg::OP_READ);
                    n_stage     = i2cm_pkg::STG_DEV_W;
                    n_abort     = 1'b0;
                    n_phase     = i2cm_pkg::PH_START0;
                end
            end
            i2cm_pkg::PH_START0: begin
                res.scl_out = 1'b0;
                n_phase     = i2cm_pkg::PH_START1;
            end
            i2cm_pkg::PH_START1: begin
                n_phase = i2cm_pkg::PH_START2;
            end
            i2cm_pkg::PH_START2: begin
                res.sda_out = 1'b0;
                n_shift     = {r_dev, (r_stage == i2cm_pkg::STG_DEV_R)};
                n_bit_idx   = 3'd0;
                n_phase     = i2cm_pkg::PH_TX_LOW;
            end
            i2cm_pkg::PH_TX_LOW: begin
                res.scl_out = 1'b0;
                res.sda_out = bitv;
                n_phase     = i2cm_pkg::PH_TX_HIGH;
            end
            i2cm_pkg::PH_TX_HIGH: begin
                res.sda_out = bitv;
                n_shift     = {r_shift[6:0], 1'b0};
                n_bit_idx   = bit_inc;
                if (bit_inc == 3'd0) begin
                    n_phase   = i2cm_pkg::PH_ACK_LOW;
                    n_ack_cnt = 8'd0;
                end else begin
                    n_phase = i2cm_pkg::PH_TX_LOW;
                end
            end
            i2cm_pkg::PH_ACK_LOW: begin
                res.scl_out = 1'b0;
                n_phase     = i2cm_pkg::PH_ACK_HIGH;
            end
            i2cm_pkg::PH_ACK_HIGH: begin
                if (i_item.sda_in) begin
                    // no acknowledge yet: wait, or give up past the timeout
                    if (r_ack_cnt >= r_ack_timeout) begin
                        n_abort = 1'b1;
                        n_phase = i2cm_pkg::PH_STOP0;
                    end else begin
                        n_ack_cnt = r_ack_cnt + 8'd1;
                    end
                end else begin
                    n_ack_cnt = 8'd0;
                    n_bit_idx = 3'd0;
                    priority if (r_stage == i2cm_pkg::STG_DEV_W) begin
                        n_shift = r_reg;
                        n_stage = i2cm_pkg::STG_REG;
                        n_phase = i2cm_pkg::PH_TX_LOW;
                    end else if (r_stage == i2cm_pkg::STG_REG && r_read_mode) begin
                        n_stage = i2cm_pkg::STG_DEV_R;
                        n_phase = i2cm_pkg::PH_START0;
                    end else if (r_stage == i2cm_pkg::STG_DEV_R) begin
                        n_shift = 8'd0;
                        n_phase = (r_left == 16'd0) ? i2cm_pkg::PH_STOP0
                                                    : i2cm_pkg::PH_RX_LOW;
                    end else if (r_left == 16'd0) begin
                        n_phase = i2cm_pkg::PH_STOP0;
                    end else begin
                        n_shift         = i_item.write_data;
                        res.data_taken  = 1'b1;
                        n_left          = r_left - 16'd1;
                        n_stage         = i2cm_pkg::STG_DATA;
                        n_phase         = i2cm_pkg::PH_TX_LOW;
                    end
                end
            end
            i2cm_pkg::PH_RX_LOW: begin
                res.scl_out = 1'b0;
                n_phase     = i2cm_pkg::PH_RX_HIGH;
            end
            i2cm_pkg::PH_RX_HIGH: begin
                n_bit_idx = bit_inc;
                if (bit_inc == 3'd0) begin
                    res.read_data  = rx_shift;
                    res.read_valid = 1'b1;
                    n_shift        = 8'd0;
                    n_left         = r_left - 16'd1;
                    n_phase        = i2cm_pkg::PH_MACK_LOW;
                end else begin
                    n_shift = rx_shift;
                    n_phase = i2cm_pkg::PH_RX_LOW;
                end
            end
            i2cm_pkg::PH_MACK_LOW: begin
                // nack on the last byte
                res.scl_out = 1'b0;
                res.sda_out = (r_left == 16'd0);
                n_phase     = i2cm_pkg::PH_MACK_HIGH;
            end
            i2cm_pkg::PH_MACK_HIGH: begin
                res.sda_out = (r_left == 16'd0);
                n_phase     = (r_left == 16'd0) ? i2cm_pkg::PH_STOP0
                                                : i2cm_pkg::PH_RX_LOW;
            end
            i2cm_pkg::PH_STOP0: begin
                res.scl_out = 1'b0;
                res.sda_out = 1'b0;
                n_phase     = i2cm_pkg::PH_STOP1;
            end
            i2cm_pkg::PH_STOP1: begin
                res.sda_out = 1'b0;
                n_phase     = i2cm_pkg::PH_STOP2;
            end
            i2cm_pkg::PH_STOP2: begin
                res.done_res = 1'b1;
                res.error    = r_abort;
                n_abort      = 1'b0;
                n_phase      = i2cm_pkg::PH_IDLE;
            end
            default: begin
                n_phase = i2cm_pkg::PH_IDLE;
            end
        endcase

        res.busy_res = (n_phase != i2cm_pkg::PH_IDLE);
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_ack_timeout <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cm_pkg::PH_IDLE;
            r_bit_idx   <= 3'd0;
            r_shift     <= 8'd0;
            r_left      <= 16'd0;
            r_ack_cnt   <= 8'd0;
            r_dev       <= 7'd0;
            r_reg       <= 8'd0;
            r_read_mode <= 1'b0;
            r_stage     <= i2cm_pkg::STG_DEV_W;
            r_abort     <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_bit_idx   <= n_bit_idx;
            r_shift     <= n_shift;
            r_left      <= n_left;
            r_ack_cnt   <= n_ack_cnt;
            r_dev       <= n_dev;
            r_reg       <= n_reg;
            r_read_mode <= n_read_mode;
            r_stage     <= n_stage;
            r_abort     <= n_abort;
        end
    end

    `I2CM_ASSERT(a_ack_starts_on_byte, i_clk, i_rst_n, (r_phase != i2cm_pkg::PH_ACK_LOW) || (r_bit_idx == 3'd0))
    `I2CM_ASSERT_NEXT(a_stop_ends_idle, i_clk, i_rst_n, i_accept && (r_phase == i2cm_pkg::PH_STOP2), r_phase == i2cm_pkg::PH_IDLE)

endmodule

/* rtl/i2cm_skid.sv */
// two-entry output buffer between the sequencer and the result channel
`include "i2c_master_register_access_defines.svh"

module i2cm_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2cm_pkg::t_out_item i_item,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2cm_pkg::t_out_item o_out_item
);

    logic                r_out_valid;
    logic                r_skid_valid;
    i2cm_pkg::t_out_item r_out;
    i2cm_pkg::t_out_item r_skid;
    logic                take;

    assign take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_load;
            end
        end else if (i_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload follows the valid bits above
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : i_item;
        end
        if (r_out_valid && !take && i_load) begin
            r_skid <= i_item;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `I2CM_ASSERT(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid)
    `I2CM_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_out_stall, !r_skid_valid)

endmodule

/* rtl/i2c_master_register_access.sv */
// top level of the i2c register access master
//
//   channel   direction  handshake                    payload
//   in        input      i_in_valid / o_in_stall      i2cm_pkg::t_in_item
//   out       output     o_out_valid / i_out_stall    i2cm_pkg::t_out_item
//   cfg       input      i_cfg_wr_en                  ack_timeout, 8 bits
//
// one item in, one result out; an item can be taken every cycle while the in side does not stall
// each result is registered and leaves from the output register
// a second output stage absorbs one result while the out side stalls,
// then the in side stalls until it drains
// synchronous active-low reset: sequencer idle, buffers empty, timeout 250

module i2c_master_register_access (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  i2cm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2cm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data
);

    logic                accept;
    logic                full;
    i2cm_pkg::t_out_item result;

    assign accept     = i_in_valid && !full;
    assign o_in_stall = full;

    i2cm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (result)
    );

    i2cm_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_item      (result),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* tb/tb_i2c_master_register_access.sv */
// testbench for the i2c register access master: bus-level predictor, slave ack model, scoreboard
module tb_i2c_master_register_access;
    timeunit 1ns;
    timeprecision 1ps;

    // operation three is not a command and behaves as a plain tick
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NEVER = -1;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    i2cm_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    i2cm_pkg::t_out_item o_out_item;
    logic                i_cfg_wr_en = 1'b0;
    logic [7:0]          i_cfg_wr_data = '0;

    i2c_master_register_access dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predicted master state
    logic [3:0]  seq_phase = i2cm_pkg::PH_IDLE;
    logic [2:0]  bit_cnt = '0;
    logic [7:0]  shifter = '0;
    logic [15:0] remaining = '0;
    logic [7:0]  ack_waits = '0;
    logic [6:0]  dev_latched = '0;
    logic [7:0]  reg_latched = '0;
    logic        is_read = 1'b0;
    logic [1:0]  stage_q = i2cm_pkg::STG_DEV_W;
    logic        aborting = 1'b0;
    logic [7:0]  timeout_cfg = i2cm_pkg::ACK_TIMEOUT_RESET;

    // target-side behavior during acknowledge
    int acks_given = 0;
    int abort_ack = NEVER;
    int ack_hold = 0;

    i2cm_pkg::t_out_item expected_lines_q[$];
    int send_gap_pct = 0;
    int out_stall_pct = 0;
    int items_sent = 0;
    int mismatches = 0;
    int cycle_count = 0;

    function automatic i2cm_pkg::t_out_item advance_sequencer(i2cm_pkg::t_in_item it);
        i2cm_pkg::t_out_item r;
        logic msb;
        r = '0;
        r.scl_out = 1'b1;
        r.sda_out = 1'b1;
        msb = shifter[7];
        case (seq_phase)
            i2cm_pkg::PH_IDLE: begin
                if (it.operation == i2cm_pkg::OP_WRITE || it.operation == i2cm_pkg::OP_READ) begin
                    dev_latched = it.dev_addr;
                    reg_latched = it.reg_addr;
                    remaining = it.byte_count;
                    is_read = (it.operation == i2cm_pkg::OP_READ);
                    stage_q = i2cm_pkg::STG_DEV_W;
                    aborting = 1'b0;
                    seq_phase = i2cm_pkg::PH_START0;
                end
            end
            i2cm_pkg::PH_START0: begin
                r.scl_out = 1'b0;
                seq_phase = i2cm_pkg::PH_START1;
            end
            i2cm_pkg::PH_START1: seq_phase = i2cm_pkg::PH_START2;
            i2cm_pkg::PH_START2: begin
                r.sda_out = 1'b0;
                shifter = {dev_latched, stage_q == i2cm_pkg::STG_DEV_R};
                bit_cnt = '0;
                seq_phase = i2cm_pkg::PH_TX_LOW;
            end
            i2cm_pkg::PH_TX_LOW: begin
                r.scl_out = 1'b0;
                r.sda_out = msb;
                seq_phase = i2cm_pkg::PH_TX_HIGH;
            end
            i2cm_pkg::PH_TX_HIGH: begin
                r.sda_out = msb;
                shifter = shifter << 1;
                bit_cnt = bit_cnt + 3'd1;
                if (bit_cnt == 0) begin
                    ack_waits = '0;
                    seq_phase = i2cm_pkg::PH_ACK_LOW;
                end else begin
                    seq_phase = i2cm_pkg::PH_TX_LOW;
                end
            end
            i2cm_pkg::PH_ACK_LOW: begin
                r.scl_out = 1'b0;
                seq_phase = i2cm_pkg::PH_ACK_HIGH;
            end
            i2cm_pkg::PH_ACK_HIGH: begin
                if (it.sda_in) begin
                    if (ack_waits >= timeout_cfg) begin
                        aborting = 1'b1;
                        seq_phase = i2cm_pkg::PH_STOP0;
                    end else begin
                        ack_waits = ack_waits + 8'd1;
                    end
                end else begin
                    ack_waits = '0;
                    bit_cnt = '0;
                    if (stage_q == i2cm_pkg::STG_DEV_W) begin
                        shifter = reg_latched;
                        stage_q = i2cm_pkg::STG_REG;
                        seq_phase = i2cm_pkg::PH_TX_LOW;
                    end else if (stage_q == i2cm_pkg::STG_REG && is_read) begin
                        // repeated start for the read address
                        stage_q = i2cm_pkg::STG_DEV_R;
                        seq_phase = i2cm_pkg::PH_START0;
                    end else if (stage_q == i2cm_pkg::STG_DEV_R) begin
                        shifter = '0;
                        seq_phase = (remaining == 0) ? i2cm_pkg::PH_STOP0
                                                     : i2cm_pkg::PH_RX_LOW;
                    end else if (remaining == 0) begin
                        seq_phase = i2cm_pkg::PH_STOP0;
                    end else begin
                        shifter = it.write_data;
                        r.data_taken = 1'b1;
                        remaining = remaining - 16'd1;
                        stage_q = i2cm_pkg::STG_DATA;
                        seq_phase = i2cm_pkg::PH_TX_LOW;
                    end
                end
            end
            i2cm_pkg::PH_RX_LOW: begin
                r.scl_out = 1'b0;
                seq_phase = i2cm_pkg::PH_RX_HIGH;
            end
            i2cm_pkg::PH_RX_HIGH: begin
                shifter = {shifter[6:0], it.sda_in};
                bit_cnt = bit_cnt + 3'd1;
                if (bit_cnt == 0) begin
                    r.read_data = shifter;
                    r.read_valid = 1'b1;
                    shifter = '0;
                    remaining = remaining - 16'd1;
                    seq_phase = i2cm_pkg::PH_MACK_LOW;
                end else begin
                    seq_phase = i2cm_pkg::PH_RX_LOW;
                end
            end
            i2cm_pkg::PH_MACK_LOW: begin
                // nack on the last byte
                r.scl_out = 1'b0;
                r.sda_out = (remaining == 0);
                seq_phase = i2cm_pkg::PH_MACK_HIGH;
            end
            i2cm_pkg::PH_MACK_HIGH: begin
                r.sda_out = (remaining == 0);
                seq_phase = (remaining == 0) ? i2cm_pkg::PH_STOP0 : i2cm_pkg::PH_RX_LOW;
            end
            i2cm_pkg::PH_STOP0: begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
                seq_phase = i2cm_pkg::PH_STOP1;
            end
            i2cm_pkg::PH_STOP1: begin
                r.sda_out = 1'b0;
                seq_phase = i2cm_pkg::PH_STOP2;
            end
            i2cm_pkg::PH_STOP2: begin
                r.done_res = 1'b1;
                r.error = aborting;
                aborting = 1'b0;
                seq_phase = i2cm_pkg::PH_IDLE;
            end
            default: seq_phase = i2cm_pkg::PH_IDLE;
        endcase
        r.busy_res = (seq_phase != i2cm_pkg::PH_IDLE);
        return r;
    endfunction

    function automatic int pick_hold();
        int roll;
        int cap;
        roll = $urandom_range(0, 99);
        cap = (timeout_cfg < 4) ? int'(timeout_cfg) : 4;
        if (roll < 75) return 0;
        if (roll < 95) return $urandom_range(0, cap);
        // longest wait that still gets through, for a timeout up to 16; above that, the short cap
        return (timeout_cfg <= 16) ? int'(timeout_cfg) : cap;
    endfunction

    // target answer on the data line, driven low to acknowledge
    function automatic logic target_sda();
        if (seq_phase != i2cm_pkg::PH_ACK_HIGH) return 1'($urandom);
        if (acks_given == abort_ack) return 1'b1;
        if (ack_hold > 0) begin
            ack_hold--;
            return 1'b1;
        end
        acks_given++;
        ack_hold = pick_hold();
        return 1'b0;
    endfunction

    function automatic i2cm_pkg::t_in_item random_item();
        i2cm_pkg::t_in_item it;
        it.operation = 2'($urandom_range(0, 3));
        it.dev_addr = 7'($urandom);
        it.reg_addr = 8'($urandom);
        it.byte_count = 16'($urandom);
        it.write_data = 8'($urandom);
        it.sda_in = 1'($urandom);
        return it;
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        i2cm_pkg::t_out_item want;
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_lines_q.size() == 0) begin
                $error("result item with nothing expected");
                mismatches++;
            end else begin
                want = expected_lines_q.pop_front();
                check_field("scl_out", 8'(want.scl_out), 8'(o_out_item.scl_out));
                check_field("sda_out", 8'(want.sda_out), 8'(o_out_item.sda_out));
                check_field("read_data", want.read_data, o_out_item.read_data);
                check_field("read_valid", 8'(want.read_valid), 8'(o_out_item.read_valid));
                check_field("data_taken", 8'(want.data_taken), 8'(o_out_item.data_taken));
                check_field("done_res", 8'(want.done_res), 8'(o_out_item.done_res));
                check_field("error", 8'(want.error), 8'(o_out_item.error));
                check_field("busy_res", 8'(want.busy_res), 8'(o_out_item.busy_res));
            end
        end
    end

    task automatic send_item(input i2cm_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_lines_q.push_back(advance_sequencer(it));
        items_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_lines_q.size() != 0);
    endtask

    task automatic write_ack_timeout(input logic [7:0] value);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        timeout_cfg = value;
    endtask

    task automatic send_ticks(input int count);
        i2cm_pkg::t_in_item it;
        repeat (count) begin
            it = random_item();
            it.operation = $urandom_range(0, 1) ? i2cm_pkg::OP_TICK : OP_SPARE;
            send_item(it);
        end
    endtask

    // one command from idle, then ticks until the sequencer is idle again
    task automatic run_transaction(input logic [1:0] op, input logic [6:0] dev,
                                   input logic [7:0] register_addr,
                                   input logic [15:0] count,
                                   input int abort_at, input int first_hold,
                                   input int noise_pct);
        i2cm_pkg::t_in_item it;
        acks_given = 0;
        abort_ack = abort_at;
        ack_hold = (first_hold < 0) ? pick_hold() : first_hold;
        it = random_item();
        it.operation = op;
        it.dev_addr = dev;
        it.reg_addr = register_addr;
        it.byte_count = count;
        send_item(it);
        do begin
            it = random_item();
            if ($urandom_range(0, 99) >= noise_pct) it.operation = i2cm_pkg::OP_TICK;
            it.sda_in = target_sda();
            send_item(it);
        end while (seq_phase != i2cm_pkg::PH_IDLE);
    endtask

    task automatic test_idle_ticks();
        i2cm_pkg::t_in_item it;
        it = '0;
        send_item(it);
        it = '1;
        it.operation = OP_SPARE;
        send_item(it);
        it.operation = i2cm_pkg::OP_TICK;
        send_item(it);
    endtask

    task automatic test_zero_count_transfers();
        run_transaction(i2cm_pkg::OP_WRITE, 7'h7f, 8'hff, 16'd0, NEVER, 0, 0);
        run_transaction(i2cm_pkg::OP_READ, 7'h00, 8'h00, 16'd0, NEVER, 0, 0);
    endtask

    // short transfers with commands thrown in while busy
    task automatic test_data_transfers();
        run_transaction(i2cm_pkg::OP_WRITE, 7'h55, 8'h2a, 16'd2, NEVER, NEVER, 40);
        run_transaction(i2cm_pkg::OP_READ, 7'h2a, 8'hd5, 16'd2, NEVER, NEVER, 40);
        send_ticks(2);
    endtask

    task automatic test_ack_timeout();
        write_ack_timeout(8'd255);
        // longest tolerated wait on the first ack, then give up on the next
        run_transaction(i2cm_pkg::OP_WRITE, 7'h12, 8'h34, 16'hffff, 1, 255, 0);
        run_transaction(i2cm_pkg::OP_READ, 7'h6c, 8'h81, 16'hffff, 2, 0, 0);
        write_ack_timeout(8'd0);
        run_transaction(i2cm_pkg::OP_WRITE, 7'h01, 8'h80, 16'd3, 0, 0, 0);
        run_transaction(i2cm_pkg::OP_READ, 7'h40, 8'h7f, 16'd1, 1, 0, 0);
        run_transaction(i2cm_pkg::OP_WRITE, 7'h3c, 8'hc3, 16'd1, 2, 0, 0);
    endtask

    task automatic test_random_traffic(input int count);
        int start;
        int roll;
        int bytes;
        int abort_at;
        logic [1:0] op;
        start = items_sent;
        while (items_sent - start < count) begin
            op = $urandom_range(0, 1) ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ;
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                // huge count, cut short by a missing ack
                bytes = $urandom_range(0, 65535);
                abort_at = $urandom_range(0, (op == i2cm_pkg::OP_WRITE) ? 3 : 2);
            end else begin
                bytes = (roll < 20) ? $urandom_range(4, 9) : $urandom_range(0, 3);
                abort_at = ($urandom_range(0, 99) < 12)
                    ? $urandom_range(0, (op == i2cm_pkg::OP_WRITE) ? bytes + 1 : 2) : NEVER;
            end
            run_transaction(op, 7'($urandom), 8'($urandom), 16'(bytes), abort_at, NEVER, 15);
            send_ticks($urandom_range(0, 3));
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct = 23;
        out_stall_pct = 55;
        test_idle_ticks();
        test_zero_count_transfers();
        test_data_transfers();
        test_ack_timeout();

        write_ack_timeout(8'd5);
        test_random_traffic(150);

        send_gap_pct = 55;
        out_stall_pct = 23;
        write_ack_timeout(8'd0);
        test_random_traffic(150);

        send_gap_pct = 0;
        out_stall_pct = 0;
        write_ack_timeout(i2cm_pkg::ACK_TIMEOUT_RESET);
        test_random_traffic(150);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
